// File: hdl/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg
// Shared constants, tables and helpers for the swerve forward kinematics block.
// ----------------------------------------------------------------------------
package sfk_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int AtanDepth = 24;

  localparam logic [1:0] CfgHalfLength = 2'd0;
  localparam logic [1:0] CfgHalfWidth  = 2'd1;
  localparam logic [1:0] CfgTurnGain   = 2'd2;

  localparam logic [15:0] HalfLengthReset = 16'd3277;
  localparam logic [15:0] HalfWidthReset  = 16'd3277;
  localparam logic [23:0] TurnGainReset   = 24'd409600;

  localparam logic [24:0] WheelK    = 25'd23050606;
  localparam logic [31:0] AngOff    = 32'd565219011;
  localparam logic [31:0] Q28Pi     = 32'd843314856;
  localparam logic [31:0] Q28TwoPi  = 32'd1686629712;
  localparam logic [31:0] Q28HalfPi = 32'd421657428;
  localparam logic [29:0] CordicX0  = 30'd163008219;

  localparam logic [27:0] AtanQ28 [AtanDepth] = '{
    28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
    28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
    28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
    28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64, 28'd32
  };

  localparam int V_W   = 27;
  localparam int XY_W  = 30;
  localparam int Z_W   = 31;
  localparam int P_W   = V_W + XY_W;
  localparam int SX_W  = P_W + 2;
  localparam int HP_W  = 17 + XY_W;
  localparam int L_W   = 33;
  localparam int PW_W  = V_W + L_W;
  localparam int SW_W  = PW_W + 2;
  localparam int VQ_W  = SX_W - 30;
  localparam int SQ_N  = 28;
  localparam int RAD_W = 2 * SQ_N;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// File: hdl/swerve_forward_kinematics.sv
// ----------------------------------------------------------------------------
// swerve_forward_kinematics
// Four-wheel swerve forward kinematics: body velocity, yaw rate, signed speed.
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// input    | in_valid_i / in_stall_o   | speed_*_i (16 s), angle_*_i (15 u)
// output   | out_valid_o / out_stall_i | body_vel_x/y_o, yaw_rate_o, signed_speed_o
// config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled; data passes through
// the CORDIC rotation pipeline, arithmetic stages and 28-stage square root pipeline.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline and raises in_stall_o.
// ----------------------------------------------------------------------------
module swerve_forward_kinematics #(
  parameter int CORDIC_STAGES = sfk_pkg::CordicStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] speed_front_left_i,
  input  logic signed [15:0] speed_rear_left_i,
  input  logic signed [15:0] speed_rear_right_i,
  input  logic signed [15:0] speed_front_right_i,
  input  logic [14:0]        angle_front_left_i,
  input  logic [14:0]        angle_rear_left_i,
  input  logic [14:0]        angle_rear_right_i,
  input  logic [14:0]        angle_front_right_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] body_vel_x_o,
  output logic signed [31:0] body_vel_y_o,
  output logic signed [31:0] yaw_rate_o,
  output logic signed [31:0] signed_speed_o
);
  import sfk_pkg::*;

  localparam int NCS = (CORDIC_STAGES > AtanDepth) ? AtanDepth : CORDIC_STAGES;

  logic en;
  logic [15:0] hl_q, hw_q;
  logic [23:0] tg_q;

  logic signed [15:0] spd [4];
  logic [14:0]        ang [4];

  // CORDIC pipeline
  logic                   cv_q   [NCS+1];
  logic signed [XY_W-1:0] cx_q   [NCS+1][4];
  logic signed [XY_W-1:0] cy_q   [NCS+1][4];
  logic signed [Z_W-1:0]  cz_q   [NCS+1][4];
  logic                   cneg_q [NCS+1][4];
  logic signed [V_W-1:0]  cvel_q [NCS+1][4];

  logic signed [XY_W-1:0] cx_d [NCS][4];
  logic signed [XY_W-1:0] cy_d [NCS][4];
  logic signed [Z_W-1:0]  cz_d [NCS][4];

  logic signed [Z_W-1:0]  z0_d [4];
  logic                   neg0_d [4];
  logic signed [V_W-1:0]  v0_d [4];

  // arithmetic stages
  logic                   csv_q, m1v_q, m2v_q, m3v_q, m4v_q, m5v_q;
  logic signed [XY_W-1:0] c_q [4];
  logic signed [XY_W-1:0] s_q [4];
  logic signed [V_W-1:0]  v5_q [4];
  logic signed [P_W-1:0]  pxc_q [4];
  logic signed [P_W-1:0]  pxs_q [4];
  logic signed [HP_W-1:0] hls_q [4];
  logic signed [HP_W-1:0] hwc_q [4];
  logic signed [V_W-1:0]  v1_q [4];
  logic signed [L_W-1:0]  lever_q [4];
  logic signed [L_W-1:0]  lever_d [4];
  logic signed [V_W-1:0]  v2_q [4];
  logic signed [SX_W-1:0] sx2_q, sy2_q;
  logic signed [PW_W-1:0] pw_q [4];
  logic signed [SX_W-1:0] sx3_q, sy3_q;
  logic signed [SW_W-1:0] sw4_q;
  logic signed [VQ_W-1:0] vx24_q, vy24_q;
  logic signed [31:0]     bvx4_q, bvy4_q;
  logic                   neg4_q;
  logic signed [SW_W-24+25-1:0] yawp_q;
  logic [2*VQ_W-1:0]      sqx_q, sqy_q;
  logic signed [31:0]     bvx5_q, bvy5_q;
  logic                   neg5_q;

  // square root pipeline
  logic                   qv_q    [SQ_N+1];
  logic [SQ_N+1:0]        qrem_q  [SQ_N+1];
  logic [SQ_N-1:0]        qroot_q [SQ_N+1];
  logic [RAD_W-1:0]       qval_q  [SQ_N+1];
  logic signed [31:0]     qbx_q   [SQ_N+1];
  logic signed [31:0]     qby_q   [SQ_N+1];
  logic signed [31:0]     qyaw_q  [SQ_N+1];
  logic                   qneg_q  [SQ_N+1];
  logic [SQ_N+1:0]        qrem_d  [SQ_N];
  logic [SQ_N-1:0]        qroot_d [SQ_N];

  logic                   out_valid_q;
  logic signed [31:0]     bvx_q, bvy_q, yaw_q, spd_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign spd[0] = speed_front_left_i;
  assign spd[1] = speed_rear_left_i;
  assign spd[2] = speed_rear_right_i;
  assign spd[3] = speed_front_right_i;
  assign ang[0] = angle_front_left_i;
  assign ang[1] = angle_rear_left_i;
  assign ang[2] = angle_rear_right_i;
  assign ang[3] = angle_front_right_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q <= HalfLengthReset;
      hw_q <= HalfWidthReset;
      tg_q <= TurnGainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfLength: hl_q <= cfg_data_i[15:0];
        CfgHalfWidth:  hw_q <= cfg_data_i[15:0];
        CfgTurnGain:   tg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage: wheel speed scaling and angle folding
  for (genvar k = 0; k < 4; k++) begin : g_pre
    logic signed [41:0]    vprod;
    logic signed [V_W-1:0] vlin;
    logic signed [31:0]    th, th1;
    assign vprod = spd[k] * $signed({1'b0, WheelK});
    assign vlin  = V_W'(vprod >>> 14);
    assign v0_d[k] = (k >= 2) ? -vlin : vlin;
    assign th  = $signed(AngOff) - $signed({1'b0, ang[k], 16'd0});
    assign th1 = (th < -$signed(Q28Pi)) ? th + $signed(Q28TwoPi) : th;
    always_comb begin
      if (th1 > $signed(Q28HalfPi)) begin
        z0_d[k]   = Z_W'(th1 - $signed(Q28Pi));
        neg0_d[k] = 1'b1;
      end else if (th1 < -$signed(Q28HalfPi)) begin
        z0_d[k]   = Z_W'(th1 + $signed(Q28Pi));
        neg0_d[k] = 1'b1;
      end else begin
        z0_d[k]   = Z_W'(th1);
        neg0_d[k] = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    for (genvar k = 0; k < 4; k++) begin : g_wheel
      logic signed [XY_W-1:0] dx, dy;
      logic signed [Z_W-1:0]  da;
      assign dx = cy_q[i][k] >>> i;
      assign dy = cx_q[i][k] >>> i;
      assign da = $signed({{(Z_W-28){1'b0}}, AtanQ28[i]});
      assign cx_d[i][k] = cz_q[i][k][Z_W-1] ? cx_q[i][k] + dx : cx_q[i][k] - dx;
      assign cy_d[i][k] = cz_q[i][k][Z_W-1] ? cy_q[i][k] - dy : cy_q[i][k] + dy;
      assign cz_d[i][k] = cz_q[i][k][Z_W-1] ? cz_q[i][k] + da : cz_q[i][k] - da;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [HP_W:0] acc;
      acc = '0;
      acc = (k == 0 || k == 3) ? acc + hls_q[k] : acc - hls_q[k];
      acc = (k >= 2) ? acc + hwc_q[k] : acc - hwc_q[k];
      lever_d[k] = L_W'(acc >>> 14);
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [SQ_N+3:0] rem_t, trial;
    logic            ge;
    assign rem_t = {qrem_q[j], qval_q[j][RAD_W-1 -: 2]};
    assign trial = {2'b00, qroot_q[j], 2'b01};
    assign ge    = rem_t >= trial;
    assign qrem_d[j]  = ge ? (SQ_N+2)'(rem_t - trial) : (SQ_N+2)'(rem_t);
    assign qroot_d[j] = {qroot_q[j][SQ_N-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NCS; i++) cv_q[i] <= 1'b0;
      for (int j = 0; j <= SQ_N; j++) qv_q[j] <= 1'b0;
      csv_q <= 1'b0;
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
      m3v_q <= 1'b0;
      m4v_q <= 1'b0;
      m5v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      cv_q[0] <= in_valid_i;
      for (int i = 0; i < NCS; i++) cv_q[i+1] <= cv_q[i];
      csv_q <= cv_q[NCS];
      m1v_q <= csv_q;
      m2v_q <= m1v_q;
      m3v_q <= m2v_q;
      m4v_q <= m3v_q;
      m5v_q <= m4v_q;
      qv_q[0] <= m5v_q;
      for (int j = 0; j < SQ_N; j++) qv_q[j+1] <= qv_q[j];
      out_valid_q <= qv_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        cx_q[0][k]   <= $signed(CordicX0);
        cy_q[0][k]   <= '0;
        cz_q[0][k]   <= z0_d[k];
        cneg_q[0][k] <= neg0_d[k];
        cvel_q[0][k] <= v0_d[k];
        for (int i = 0; i < NCS; i++) begin
          cx_q[i+1][k]   <= cx_d[i][k];
          cy_q[i+1][k]   <= cy_d[i][k];
          cz_q[i+1][k]   <= cz_d[i][k];
          cneg_q[i+1][k] <= cneg_q[i][k];
          cvel_q[i+1][k] <= cvel_q[i][k];
        end
        c_q[k]   <= cneg_q[NCS][k] ? -cx_q[NCS][k] : cx_q[NCS][k];
        s_q[k]   <= cneg_q[NCS][k] ? -cy_q[NCS][k] : cy_q[NCS][k];
        v5_q[k]  <= cvel_q[NCS][k];
        pxc_q[k] <= v5_q[k] * c_q[k];
        pxs_q[k] <= v5_q[k] * s_q[k];
        hls_q[k] <= $signed({1'b0, hl_q}) * s_q[k];
        hwc_q[k] <= $signed({1'b0, hw_q}) * c_q[k];
        v1_q[k]  <= v5_q[k];
        lever_q[k] <= lever_d[k];
        v2_q[k]  <= v1_q[k];
        pw_q[k]  <= v2_q[k] * lever_q[k];
      end
      sx2_q <= SX_W'(pxc_q[0]) + SX_W'(pxc_q[1]) + SX_W'(pxc_q[2]) + SX_W'(pxc_q[3]);
      sy2_q <= SX_W'(pxs_q[0]) + SX_W'(pxs_q[1]) + SX_W'(pxs_q[2]) + SX_W'(pxs_q[3]);
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      sw4_q <= SW_W'(pw_q[0]) + SW_W'(pw_q[1]) + SW_W'(pw_q[2]) + SW_W'(pw_q[3]);
      vx24_q <= VQ_W'(sx3_q >>> 30);
      vy24_q <= VQ_W'(sy3_q >>> 30);
      bvx4_q <= sat32(64'((sx3_q + (SX_W'(1) <<< 37)) >>> 38));
      bvy4_q <= sat32(64'((sy3_q + (SX_W'(1) <<< 37)) >>> 38));
      neg4_q <= sx3_q[SX_W-1];
      yawp_q <= (sw4_q >>> 24) * $signed({1'b0, tg_q});
      sqx_q  <= $unsigned((2*VQ_W)'(vx24_q) * (2*VQ_W)'(vx24_q));
      sqy_q  <= $unsigned((2*VQ_W)'(vy24_q) * (2*VQ_W)'(vy24_q));
      bvx5_q <= bvx4_q;
      bvy5_q <= bvy4_q;
      neg5_q <= neg4_q;
      qrem_q[0]  <= '0;
      qroot_q[0] <= '0;
      qval_q[0]  <= RAD_W'(sqx_q + sqy_q);
      qbx_q[0]   <= bvx5_q;
      qby_q[0]   <= bvy5_q;
      qyaw_q[0]  <= sat32(64'((yawp_q + ($bits(yawp_q))'(1 <<< 27)) >>> 28));
      qneg_q[0]  <= neg5_q;
      for (int j = 0; j < SQ_N; j++) begin
        qrem_q[j+1]  <= qrem_d[j];
        qroot_q[j+1] <= qroot_d[j];
        qval_q[j+1]  <= qval_q[j] << 2;
        qbx_q[j+1]   <= qbx_q[j];
        qby_q[j+1]   <= qby_q[j];
        qyaw_q[j+1]  <= qyaw_q[j];
        qneg_q[j+1]  <= qneg_q[j];
      end
      bvx_q <= qbx_q[SQ_N];
      bvy_q <= qby_q[SQ_N];
      yaw_q <= qyaw_q[SQ_N];
      spd_q <= qneg_q[SQ_N]
             ? -$signed(32'(({1'b0, qroot_q[SQ_N]} + (SQ_N+1)'(128)) >> 8))
             :  $signed(32'(({1'b0, qroot_q[SQ_N]} + (SQ_N+1)'(128)) >> 8));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign body_vel_x_o   = bvx_q;
  assign body_vel_y_o   = bvy_q;
  assign yaw_rate_o     = yaw_q;
  assign signed_speed_o = spd_q;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> cv_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(m3v_q) && $stable(m5v_q) && $stable(csv_q))
    else $error("pipeline advanced while output stalled");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !body_vel_x_o[31] && (body_vel_x_o != 32'sd0) |-> !signed_speed_o[31])
    else $error("signed speed sign disagrees with forward velocity");

endmodule
